FILE: src/achp_pkg.sv
// ---------------------------------------------------------------------------
// achp_pkg
// Shared types, register map, field widths and the sine table builder for
// the clock hand end point core.
// ---------------------------------------------------------------------------
package achp_pkg;

    // Field widths fixed by the interface
    localparam int RAW_W       = 8;
    localparam int CENTER_W    = 10;
    localparam int LEN_W       = 9;
    localparam int PIX_W       = 11;
    localparam int CLAMP_W     = 6;
    localparam int TENTHS_W    = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Defaults for the top level parameters
    localparam int ANGLE_STEPS_DEF   = 3600;
    localparam int FRACTION_BITS_DEF = 15;

    // Angle scaling: tenths of a degree per turn, reciprocal shift
    localparam int FULL_TURN_TENTHS = 3600;
    localparam int SCALE_SHIFT      = 28;

    // Clamp limits
    localparam logic [CLAMP_W-1:0] HOUR_MAX   = 6'd11;
    localparam logic [CLAMP_W-1:0] MINSEC_MAX = 6'd59;

    // Tenths of a degree per unit
    localparam logic [TENTHS_W-1:0] SEC_TENTHS      = 12'd60;
    localparam logic [TENTHS_W-1:0] MIN_TENTHS      = 12'd60;
    localparam logic [TENTHS_W-1:0] HOUR_TENTHS     = 12'd300;
    localparam logic [TENTHS_W-1:0] HOUR_MIN_TENTHS = 12'd5;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MINUTE_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOUR_LENGTH   = 3'd4;

    // Register reset values
    localparam logic [CENTER_W-1:0] ORIGIN_X_RST      = 10'd320;
    localparam logic [CENTER_W-1:0] ORIGIN_Y_RST      = 10'd240;
    localparam logic [LEN_W-1:0]    SECOND_LENGTH_RST = 9'd150;
    localparam logic [LEN_W-1:0]    MINUTE_LENGTH_RST = 9'd180;
    localparam logic [LEN_W-1:0]    HOUR_LENGTH_RST   = 9'd133;

    // Q2.62 constants for the table builder
    localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef struct packed {
        logic signed [RAW_W-1:0] hour_raw;
        logic signed [RAW_W-1:0] minute_raw;
        logic signed [RAW_W-1:0] second_raw;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] second_end_x;
        logic [PIX_W-1:0] second_end_y;
        logic [PIX_W-1:0] minute_end_x;
        logic [PIX_W-1:0] minute_end_y;
        logic [PIX_W-1:0] hour_end_x;
        logic [PIX_W-1:0] hour_end_y;
        logic             hour_ok;
        logic             minute_ok;
        logic             second_ok;
    } out_item_t;

    typedef struct packed {
        logic hour_ok;
        logic minute_ok;
        logic second_ok;
    } ok_flags_t;

    // Q2.62 product, low 64 bits of (a*b) >> 62
    function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Sine of a Q2.62 angle by Horner-form Taylor series, rounded half up
    // to fb fraction bits. Evaluated at elaboration only.
    function automatic logic [31:0] sine_q62_round(logic [63:0] x, int fb);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = q62_mul(x, x);
        t  = ONE_Q62;
        // Highest term first, divisor (2k)(2k+1) for k = 11 down to 1
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd506;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd420;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd342;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd272;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd210;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd156;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd110;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd72;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd42;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd20;
        t  = ONE_Q62 - q62_mul(x2, t) / 64'd6;
        t = q62_mul(x, t);
        t = (t + (64'd1 << (61 - fb))) >> (62 - fb);
        return t[31:0];
    endfunction

endpackage

FILE: src/achp_time_angle.sv
// ---------------------------------------------------------------------------
// achp_time_angle
// Clamps the raw time fields, forms each hand's angle in tenths of a degree
// and scales it to table steps. Registered output.
// ---------------------------------------------------------------------------
module achp_time_angle
    import achp_pkg::*;
#(
    parameter int ANGLE_STEPS = ANGLE_STEPS_DEF,
    localparam int ANGLE_W    = $clog2(ANGLE_STEPS)
)
(
    input  logic               clk,
    input  logic               en,
    input  in_item_t           item,
    output logic [ANGLE_W-1:0] second_angle,
    output logic [ANGLE_W-1:0] minute_angle,
    output logic [ANGLE_W-1:0] hour_angle,
    output ok_flags_t          ok
);

    // Ceiling reciprocal: floor(t * ANGLE_STEPS / 3600) is exact for t < 4096
    localparam longint SCALE_M =
        ((longint'(ANGLE_STEPS) << SCALE_SHIFT) + FULL_TURN_TENTHS - 1) / FULL_TURN_TENTHS;
    localparam int SCALE_M_W = $clog2(SCALE_M + 1);
    localparam int SPROD_W   = TENTHS_W + SCALE_M_W;

    function automatic logic [CLAMP_W-1:0] clamp_raw(logic signed [RAW_W-1:0] v,
                                                      logic [CLAMP_W-1:0] hi);
        logic [CLAMP_W-1:0] res;
        if (v[RAW_W-1])
            res = '0;
        else if (v[RAW_W-2:0] > {1'b0, hi})
            res = hi;
        else
            res = v[CLAMP_W-1:0];
        return res;
    endfunction

    function automatic logic raw_in_range(logic signed [RAW_W-1:0] v,
                                          logic [CLAMP_W-1:0] hi);
        return !v[RAW_W-1] && (v[RAW_W-2:0] <= {1'b0, hi});
    endfunction

    function automatic logic [ANGLE_W-1:0] scale(logic [TENTHS_W-1:0] t);
        logic [SPROD_W-1:0] p;
        p = SPROD_W'(t) * SPROD_W'(SCALE_M);
        return p[SCALE_SHIFT +: ANGLE_W];
    endfunction

    logic [CLAMP_W-1:0]  hour_c;
    logic [CLAMP_W-1:0]  minute_c;
    logic [CLAMP_W-1:0]  second_c;
    logic [TENTHS_W-1:0] second_tenths;
    logic [TENTHS_W-1:0] minute_tenths;
    logic [TENTHS_W-1:0] hour_tenths;
    ok_flags_t           ok_next;

    logic [ANGLE_W-1:0]  second_angle_reg;
    logic [ANGLE_W-1:0]  minute_angle_reg;
    logic [ANGLE_W-1:0]  hour_angle_reg;
    ok_flags_t           ok_reg;

    always_comb
    begin
        hour_c   = clamp_raw(item.hour_raw, HOUR_MAX);
        minute_c = clamp_raw(item.minute_raw, MINSEC_MAX);
        second_c = clamp_raw(item.second_raw, MINSEC_MAX);

        ok_next.hour_ok   = raw_in_range(item.hour_raw, HOUR_MAX);
        ok_next.minute_ok = raw_in_range(item.minute_raw, MINSEC_MAX);
        ok_next.second_ok = raw_in_range(item.second_raw, MINSEC_MAX);

        second_tenths = TENTHS_W'(second_c) * SEC_TENTHS;
        minute_tenths = TENTHS_W'(minute_c) * MIN_TENTHS + TENTHS_W'(second_c);
        hour_tenths   = TENTHS_W'(hour_c) * HOUR_TENTHS
                      + TENTHS_W'(minute_c) * HOUR_MIN_TENTHS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            second_angle_reg <= scale(second_tenths);
            minute_angle_reg <= scale(minute_tenths);
            hour_angle_reg   <= scale(hour_tenths);
            ok_reg           <= ok_next;
        end
    end

    assign second_angle = second_angle_reg;
    assign minute_angle = minute_angle_reg;
    assign hour_angle   = hour_angle_reg;
    assign ok           = ok_reg;

endmodule

FILE: src/achp_sine_rom.sv
// ---------------------------------------------------------------------------
// achp_sine_rom
// Quarter-wave sine table with two registered read ports: one gives the
// sine of the angle, the other the negated cosine.
// ---------------------------------------------------------------------------
module achp_sine_rom
    import achp_pkg::*;
#(
    parameter int ANGLE_STEPS   = ANGLE_STEPS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int ANGLE_W      = $clog2(ANGLE_STEPS),
    localparam int SIG_W        = FRACTION_BITS + 2
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [ANGLE_W-1:0]      angle,
    output logic signed [SIG_W-1:0] sin_val,
    output logic signed [SIG_W-1:0] ncos_val
);

    localparam int          QUARTER   = ANGLE_STEPS / 4;
    localparam int          IDX_W     = $clog2(QUARTER + 1);
    localparam int          MAG_W     = FRACTION_BITS + 1;
    localparam logic [63:0] QUARTER_Q = 64'(QUARTER);
    localparam logic [63:0] STEP_Q62  = HALF_PI_Q62 / QUARTER_Q;
    localparam logic [63:0] REM_Q62   = HALF_PI_Q62 % QUARTER_Q;

    logic [MAG_W-1:0] rom_mem [0:QUARTER];

    for (genvar gi = 0; gi <= QUARTER; gi++)
    begin : g_rom
        localparam logic [63:0] X_Q62 = STEP_Q62 * 64'(gi) + (REM_Q62 * 64'(gi)) / QUARTER_Q;
        localparam logic [31:0] ENTRY = sine_q62_round(X_Q62, FRACTION_BITS);
        assign rom_mem[gi] = ENTRY[MAG_W-1:0];
    end

    // Split an angle into quadrant and mirrored table index
    function automatic logic [IDX_W+1:0] fold(logic [ANGLE_W-1:0] a);
        logic [1:0]         quad;
        logic [ANGLE_W-1:0] r;
        logic [IDX_W-1:0]   idx;
        if (a >= ANGLE_W'(3 * QUARTER))
        begin
            quad = 2'd3;
            r    = a - ANGLE_W'(3 * QUARTER);
        end
        else if (a >= ANGLE_W'(2 * QUARTER))
        begin
            quad = 2'd2;
            r    = a - ANGLE_W'(2 * QUARTER);
        end
        else if (a >= ANGLE_W'(QUARTER))
        begin
            quad = 2'd1;
            r    = a - ANGLE_W'(QUARTER);
        end
        else
        begin
            quad = 2'd0;
            r    = a;
        end
        idx = quad[0] ? IDX_W'(QUARTER) - IDX_W'(r) : IDX_W'(r);
        return {quad, idx};
    endfunction

    logic [ANGLE_W:0]   cos_sum;
    logic [ANGLE_W-1:0] cos_angle;
    logic [IDX_W+1:0]   sin_fold;
    logic [IDX_W+1:0]   cos_fold;

    logic [MAG_W-1:0]   sin_mag_reg;
    logic [MAG_W-1:0]   cos_mag_reg;
    logic               sin_neg_reg;
    logic               ncos_neg_reg;

    always_comb
    begin
        cos_sum = {1'b0, angle} + (ANGLE_W + 1)'(QUARTER);
        if (cos_sum >= (ANGLE_W + 1)'(ANGLE_STEPS))
            cos_angle = ANGLE_W'(cos_sum - (ANGLE_W + 1)'(ANGLE_STEPS));
        else
            cos_angle = cos_sum[ANGLE_W-1:0];
        sin_fold = fold(angle);
        cos_fold = fold(cos_angle);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg  <= rom_mem[sin_fold[IDX_W-1:0]];
            cos_mag_reg  <= rom_mem[cos_fold[IDX_W-1:0]];
            sin_neg_reg  <= sin_fold[IDX_W+1];
            // y runs downwards: carry minus cosine
            ncos_neg_reg <= !cos_fold[IDX_W+1];
        end
    end

    assign sin_val  = sin_neg_reg ? -$signed({1'b0, sin_mag_reg})
                                  :  $signed({1'b0, sin_mag_reg});
    assign ncos_val = ncos_neg_reg ? -$signed({1'b0, cos_mag_reg})
                                   :  $signed({1'b0, cos_mag_reg});

endmodule

FILE: src/achp_hand_tip.sv
// ---------------------------------------------------------------------------
// achp_hand_tip
// Scales sine and negated cosine by the hand length (registered products),
// then offsets from the centre and saturates to the pixel range.
// ---------------------------------------------------------------------------
module achp_hand_tip
    import achp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int SIG_W        = FRACTION_BITS + 2
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [LEN_W-1:0]        len,
    input  logic [CENTER_W-1:0]     origin_x,
    input  logic [CENTER_W-1:0]     origin_y,
    input  logic signed [SIG_W-1:0] sin_val,
    input  logic signed [SIG_W-1:0] ncos_val,
    output logic [PIX_W-1:0]        end_x,
    output logic [PIX_W-1:0]        end_y
);

    localparam int PROD_W = SIG_W + LEN_W + 1;

    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;

    assign prod_x_next = $signed({1'b0, len}) * sin_val;
    assign prod_y_next = $signed({1'b0, len}) * ncos_val;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    // Floor of the product: drop the fraction bits of the two's complement word
    function automatic logic [PIX_W-1:0] place(logic [CENTER_W-1:0] c,
                                                logic signed [PROD_W-1:0] p);
        logic signed [PIX_W-1:0] offs;
        logic signed [PIX_W:0]   sum;
        offs = p[FRACTION_BITS +: PIX_W];
        sum  = $signed({2'b00, c}) + $signed({offs[PIX_W-1], offs});
        // centre plus at most the hand length cannot pass the top of the range
        return sum[PIX_W] ? '0 : sum[PIX_W-1:0];
    endfunction

    assign end_x = place(origin_x, prod_x_reg);
    assign end_y = place(origin_y, prod_y_reg);

endmodule

FILE: src/analog_clock_hand_endpoints_core.sv
// ---------------------------------------------------------------------------
// analog_clock_hand_endpoints_core
// Clock hand tip coordinates from a raw hour, minute and second.
//
// Input channel: in_valid / in_stall / in_item, a beat moves when in_valid
// is high and in_stall low. Output channel: out_valid / out_stall / out_item,
// one result beat per input beat, in order. Configuration: cfg_valid /
// cfg_ready / cfg_index / cfg_data, always ready; write only while idle.
// Pipeline stages from input beat to result beat: input register, clamp
// and angle scaling, sine table read, length multiply, output register.
// Throughput is one item per cycle while out_stall is low. While out_stall
// holds a result, the earlier stages keep filling and in_stall rises only
// when all five stages hold an item. Reset empties the pipeline and loads
// the centre and hand lengths with 320, 240, 150, 180 and 133.
// ---------------------------------------------------------------------------
module analog_clock_hand_endpoints_core
    import achp_pkg::*;
#(
    parameter int ANGLE_STEPS   = ANGLE_STEPS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ANGLE_W = $clog2(ANGLE_STEPS);
    localparam int SIG_W   = FRACTION_BITS + 2;

    // Configuration registers
    logic [CENTER_W-1:0] origin_x_reg;
    logic [CENTER_W-1:0] origin_y_reg;
    logic [LEN_W-1:0]    second_length_reg;
    logic [LEN_W-1:0]    minute_length_reg;
    logic [LEN_W-1:0]    hour_length_reg;

    // Pipeline occupancy
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic load_s0;
    logic load_s1;
    logic load_s2;
    logic load_s3;
    logic load_out;

    in_item_t  in_item_reg;
    ok_flags_t s1_ok;
    ok_flags_t s2_ok_reg;
    ok_flags_t s3_ok_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic [ANGLE_W-1:0]      second_angle;
    logic [ANGLE_W-1:0]      minute_angle;
    logic [ANGLE_W-1:0]      hour_angle;
    logic signed [SIG_W-1:0] second_sin;
    logic signed [SIG_W-1:0] second_ncos;
    logic signed [SIG_W-1:0] minute_sin;
    logic signed [SIG_W-1:0] minute_ncos;
    logic signed [SIG_W-1:0] hour_sin;
    logic signed [SIG_W-1:0] hour_ncos;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= ORIGIN_X_RST;
            origin_y_reg      <= ORIGIN_Y_RST;
            second_length_reg <= SECOND_LENGTH_RST;
            minute_length_reg <= MINUTE_LENGTH_RST;
            hour_length_reg   <= HOUR_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                CFG_SECOND_LENGTH: second_length_reg <= cfg_data[LEN_W-1:0];
                CFG_MINUTE_LENGTH: minute_length_reg <= cfg_data[LEN_W-1:0];
                CFG_HOUR_LENGTH:   hour_length_reg   <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on
    assign load_out = !out_valid_reg || !out_stall;
    assign load_s3  = !s3_valid_reg || load_out;
    assign load_s2  = !s2_valid_reg || load_s3;
    assign load_s1  = !s1_valid_reg || load_s2;
    assign load_s0  = !s0_valid_reg || load_s1;
    assign in_stall = !load_s0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s0)
                s0_valid_reg <= in_valid;
            if (load_s1)
                s1_valid_reg <= s0_valid_reg;
            if (load_s2)
                s2_valid_reg <= s1_valid_reg;
            if (load_s3)
                s3_valid_reg <= s2_valid_reg;
            if (load_out)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s0)
            in_item_reg <= in_item;
        if (load_s2)
            s2_ok_reg <= s1_ok;
        if (load_s3)
            s3_ok_reg <= s2_ok_reg;
        if (load_out)
            out_item_reg <= out_item_next;
    end

    achp_time_angle #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_time_angle (
        .clk          (clk),
        .en           (load_s1),
        .item         (in_item_reg),
        .second_angle (second_angle),
        .minute_angle (minute_angle),
        .hour_angle   (hour_angle),
        .ok           (s1_ok)
    );

    achp_sine_rom #(
        .ANGLE_STEPS   (ANGLE_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_second_rom (
        .clk      (clk),
        .en       (load_s2),
        .angle    (second_angle),
        .sin_val  (second_sin),
        .ncos_val (second_ncos)
    );

    achp_sine_rom #(
        .ANGLE_STEPS   (ANGLE_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_minute_rom (
        .clk      (clk),
        .en       (load_s2),
        .angle    (minute_angle),
        .sin_val  (minute_sin),
        .ncos_val (minute_ncos)
    );

    achp_sine_rom #(
        .ANGLE_STEPS   (ANGLE_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hour_rom (
        .clk      (clk),
        .en       (load_s2),
        .angle    (hour_angle),
        .sin_val  (hour_sin),
        .ncos_val (hour_ncos)
    );

    achp_hand_tip #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_second_tip (
        .clk      (clk),
        .en       (load_s3),
        .len      (second_length_reg),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .sin_val  (second_sin),
        .ncos_val (second_ncos),
        .end_x    (out_item_next.second_end_x),
        .end_y    (out_item_next.second_end_y)
    );

    achp_hand_tip #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_minute_tip (
        .clk      (clk),
        .en       (load_s3),
        .len      (minute_length_reg),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .sin_val  (minute_sin),
        .ncos_val (minute_ncos),
        .end_x    (out_item_next.minute_end_x),
        .end_y    (out_item_next.minute_end_y)
    );

    achp_hand_tip #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hour_tip (
        .clk      (clk),
        .en       (load_s3),
        .len      (hour_length_reg),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .sin_val  (hour_sin),
        .ncos_val (hour_ncos),
        .end_x    (out_item_next.hour_end_x),
        .end_y    (out_item_next.hour_end_y)
    );

    assign out_item_next.hour_ok   = s3_ok_reg.hour_ok;
    assign out_item_next.minute_ok = s3_ok_reg.minute_ok;
    assign out_item_next.second_ok = s3_ok_reg.second_ok;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Back-pressure reaches the input only once every stage holds an item
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s0_valid_reg && s1_valid_reg && s2_valid_reg
                      && s3_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with a free pipeline stage");

    // An accepted beat reaches the output when out_stall stays low meanwhile
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            ##1 !out_stall |=> out_valid)
        else $error("result beat missing after five unstalled cycles");

    // A result cannot appear from an empty pipeline
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s3_valid_reg))
        else $error("result beat raised without an item in the last stage");

endmodule
